>>> src/irpn_pkg.sv
// irpn_pkg: token codes, error codes and operator helpers for the infix/postfix evaluator
// no dependencies; imported by infix_rpn_expression_evaluator_top and its testbench
package irpn_pkg;

  localparam int unsigned FUNC_W = 4;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned OP_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_DIGIT = 4'd0,
    FN_PLUS  = 4'd1,
    FN_MINUS = 4'd2,
    FN_TIMES = 4'd3,
    FN_DIV   = 4'd4,
    FN_OPEN  = 4'd5,
    FN_CLOSE = 4'd6,
    FN_SEP   = 4'd7,
    FN_END   = 4'd8
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_OVER  = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  // operator stack entry codes; none marks a pending result write
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_PLUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_MINUS = 3'd2;
  localparam logic [OP_W-1:0] OP_TIMES = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd5;

  // byte address of the notation mode register
  localparam logic [1:0] CFG_ADDR_MODE = 2'd0;

  // precedence: times and divide bind tighter
  function automatic logic prec_hi(input logic [OP_W-1:0] op);
    prec_hi = (op == OP_TIMES) || (op == OP_DIV);
  endfunction

endpackage

>>> src/infix_rpn_expression_evaluator_top.sv
// infix_rpn_expression_evaluator_top: shunting-yard evaluator with memory-held stacks
// depends on irpn_pkg
//
// Takes one key token per transfer and accepts the next one only when the current token
// is finished. Value and operator stacks sit in two synchronous memories (registered
// read); the top entries are read ahead from the memories, and after each result
// write a wait state (S_OUT) lets the new top be read back. An infix operator or a
// close pops and applies operators through S_APPLY, S_APPLY2 and S_PUSHOP; a divide
// also goes through the bit-serial divider; end applies each operator left on the
// stack, then waits while the previous result is not yet taken. No reset sweep: the
// stacks are only read below their depth. Config writes are taken at any time and
// should be made while idle.
module infix_rpn_expression_evaluator_top #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [3:0] func, [7:4] digit
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((VALUE_WIDTH+2+7)/8)*8-1:0] out_tdata, // value, then error_code
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import irpn_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VW = VALUE_WIDTH;
  localparam int OW = ((VALUE_WIDTH + 2 + 7) / 8) * 8;
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_OPLOOP, S_APPLY, S_APPLY2, S_DIVIDE, S_DIVFIN, S_PUSHOP,
    S_CLOSE, S_ENDLOOP, S_ENDFIN, S_OUT, S_FETCH
  } state_t;

  // memories
  logic [VW-1:0]   vmem [STACK_DEPTH];
  logic [OP_W-1:0] omem [STACK_DEPTH];

  state_t          state_r;
  logic            mode_r;
  logic [DW-1:0]   vdep_r, odep_r;
  logic [VW-1:0]   acc_r;
  logic            pend_r;
  err_t            err_r;
  logic [3:0]      func_r;
  logic [3:0]      digit_r;
  logic [VW-1:0]   a_r, b_r, res_r;
  logic [OP_W-1:0] op_r;
  logic [VW-1:0]   vrd_r;
  logic [OP_W-1:0] ord_r;
  logic            end_r;
  logic            out_valid_r;
  logic [VW-1:0]   out_val_r;
  err_t            out_err_r;
  // divider
  logic [VW-1:0]   dq_r, dr_r, dd_r;
  logic [CW-1:0]   dcnt_r;
  logic            dneg_r;

  logic [VW-1:0]   vmem_wd;
  logic [AW-1:0]   vmem_wa, vmem_ra;
  logic            vmem_we;
  logic [OP_W-1:0] omem_wd;
  logic [AW-1:0]   omem_wa, omem_ra;
  logic            omem_we;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_err_r, out_val_r});
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, mode_r};

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (vmem_we) vmem[vmem_wa] <= vmem_wd;
    vrd_r <= vmem[vmem_ra];
  end
  always_ff @(posedge clk) begin
    if (omem_we) omem[omem_wa] <= omem_wd;
    ord_r <= omem[omem_ra];
  end

  // helpers
  logic [VW-1:0] sub_w;
  logic          sub_ok;
  logic [VW-1:0] dr_sh;
  logic [VW-1:0] mag_a, mag_b;
  logic          push_ovf;
  assign mag_a    = a_r[VW-1] ? VW'(-a_r) : a_r;
  assign mag_b    = b_r[VW-1] ? VW'(-b_r) : b_r;
  assign dr_sh    = {dr_r[VW-2:0], dq_r[VW-1]};
  assign sub_ok   = ({dr_r[VW-1], dr_sh} >= {1'b0, dd_r});
  assign sub_w    = VW'({dr_r[VW-1], dr_sh} - {1'b0, dd_r});
  assign push_ovf = pend_r && (vdep_r >= DEPTH_MAX);

  // memory control
  always_comb begin
    vmem_we = 1'b0;
    vmem_wa = AW'(vdep_r);
    vmem_wd = res_r;
    omem_we = 1'b0;
    omem_wa = AW'(odep_r);
    omem_wd = op_r;
    vmem_ra = AW'(vdep_r - 1'b1);
    omem_ra = AW'(odep_r - 1'b1);
    case (state_r)
      S_DISPATCH: begin
        if (pend_r && func_r != FN_DIGIT && func_r <= FN_END && err_r == ERR_NONE
            && !push_ovf) begin
          vmem_we = 1'b1;
          vmem_wd = acc_r;
        end
      end
      S_APPLY: vmem_ra = AW'(vdep_r - 2'd2);
      // result replaces the lower operand, one below the reduced depth
      S_PUSHOP: begin
        if (op_r == OP_NONE) begin
          vmem_we = 1'b1;
          vmem_wa = AW'(vdep_r - 1'b1);
        end else begin
          omem_we = (odep_r < DEPTH_MAX);
        end
      end
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vdep_r      <= '0;
      odep_r      <= '0;
      acc_r       <= '0;
      pend_r      <= 1'b0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
      end_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_ENDFIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tdata[3:0];
            digit_r <= in_tdata[7:4];
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          end_r <= (func_r == FN_END);
          if (func_r == FN_END && err_r != ERR_NONE) begin
            state_r <= S_ENDFIN;
          end else if (func_r > FN_END || err_r != ERR_NONE) begin
            state_r <= S_IDLE;
          end else if (func_r == FN_DIGIT) begin
            acc_r   <= VW'(acc_r * VW'(10) + VW'(digit_r));
            pend_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (pend_r) begin
              acc_r  <= '0;
              pend_r <= 1'b0;
              if (!push_ovf) vdep_r <= vdep_r + 1'b1;
              else err_r <= ERR_OVER;
            end
            if (func_r == FN_END) begin
              state_r <= push_ovf ? S_ENDFIN : S_ENDLOOP;
            end else if (push_ovf || func_r == FN_SEP) begin
              state_r <= S_IDLE;
            end else if (mode_r) begin
              if (func_r <= FN_DIV) begin
                op_r    <= func_r[OP_W-1:0];
                state_r <= S_FETCH;
              end else begin
                state_r <= S_IDLE;
              end
            end else if (func_r <= FN_DIV) begin
              op_r    <= func_r[OP_W-1:0];
              state_r <= S_OPLOOP;
            end else if (func_r == FN_OPEN) begin
              op_r    <= OP_OPEN;
              state_r <= S_PUSHOP;
            end else begin
              state_r <= S_CLOSE;
            end
          end
        end
        // postfix operator: wait for the pushed number to be read back as top
        S_FETCH: state_r <= S_APPLY;
        // infix operator: ord_r holds operator-stack top
        S_OPLOOP: begin
          if (err_r != ERR_NONE) begin
            state_r <= S_IDLE;
          end else if (odep_r == '0 || ord_r == OP_OPEN
                       || (prec_hi(func_r[OP_W-1:0]) && !prec_hi(ord_r))) begin
            op_r    <= func_r[OP_W-1:0];
            state_r <= S_PUSHOP;
          end else begin
            op_r    <= ord_r;
            odep_r  <= odep_r - 1'b1;
            state_r <= S_APPLY;
          end
        end
        S_CLOSE: begin
          if (err_r != ERR_NONE) begin
            state_r <= S_IDLE;
          end else if (odep_r == '0) begin
            err_r   <= ERR_UNDER;
            state_r <= S_IDLE;
          end else if (ord_r == OP_OPEN) begin
            odep_r  <= odep_r - 1'b1;
            state_r <= S_IDLE;
          end else begin
            op_r    <= ord_r;
            odep_r  <= odep_r - 1'b1;
            state_r <= S_APPLY;
          end
        end
        S_ENDLOOP: begin
          if (err_r != ERR_NONE) begin
            state_r <= S_ENDFIN;
          end else if (odep_r == '0) begin
            if (vdep_r == '0) err_r <= ERR_UNDER;
            state_r <= S_ENDFIN;
          end else if (ord_r == OP_OPEN) begin
            err_r   <= ERR_UNDER;
            odep_r  <= odep_r - 1'b1;
            state_r <= S_ENDFIN;
          end else begin
            op_r    <= ord_r;
            odep_r  <= odep_r - 1'b1;
            state_r <= S_APPLY;
          end
        end
        // vrd_r now holds top value, read next-below
        S_APPLY: begin
          if (vdep_r < DW'(2)) begin
            err_r   <= ERR_UNDER;
            state_r <= end_r ? S_ENDFIN : S_IDLE;
          end else begin
            b_r     <= vrd_r;
            state_r <= S_APPLY2;
          end
        end
        S_APPLY2: begin
          a_r <= vrd_r;
          if (op_r == OP_DIV) begin
            state_r <= S_DIVFIN;
          end else begin
            if (op_r == OP_TIMES) res_r <= VW'(vrd_r * b_r);
            else res_r <= (op_r == OP_PLUS) ? VW'(vrd_r + b_r) : VW'(vrd_r - b_r);
            vdep_r  <= vdep_r - 1'b1;
            state_r <= S_PUSHOP;
            op_r    <= OP_NONE;
          end
        end
        S_DIVFIN: begin
          if (b_r == '0) begin
            err_r   <= ERR_DIV0;
            vdep_r  <= vdep_r - DW'(2);
            state_r <= end_r ? S_ENDFIN : S_IDLE;
          end else begin
            dq_r    <= mag_a;
            dd_r    <= mag_b;
            dr_r    <= '0;
            dneg_r  <= a_r[VW-1] ^ b_r[VW-1];
            dcnt_r  <= CW'(VW);
            state_r <= S_DIVIDE;
          end
        end
        // restoring divide, one bit per cycle
        S_DIVIDE: begin
          if (dcnt_r == '0) begin
            res_r   <= dneg_r ? VW'(-dq_r) : dq_r;
            vdep_r  <= vdep_r - 1'b1;
            op_r    <= OP_NONE;
            state_r <= S_PUSHOP;
          end else begin
            dr_r   <= sub_ok ? sub_w : dr_sh;
            dq_r   <= {dq_r[VW-2:0], sub_ok};
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        // no operator: result goes into the value slot at vdep-1
        S_PUSHOP: begin
          if (op_r == OP_NONE) begin
            state_r <= S_OUT;
          end else begin
            if (odep_r >= DEPTH_MAX) err_r <= ERR_OVER;
            else odep_r <= odep_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          // result written; continue the loop that applied it
          if (end_r) state_r <= S_ENDLOOP;
          else if (mode_r) state_r <= S_IDLE;
          else if (func_r == FN_CLOSE) state_r <= S_CLOSE;
          else state_r <= S_OPLOOP;
        end
        S_ENDFIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_err_r   <= err_r;
            out_val_r   <= (err_r == ERR_NONE) ? vrd_r : '0;
            vdep_r      <= '0;
            odep_r      <= '0;
            acc_r       <= '0;
            pend_r      <= 1'b0;
            err_r       <= ERR_NONE;
            end_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // depth never passes the stack size
  a_vdep: assert property (@(posedge clk) disable iff (!rst_n) vdep_r <= DEPTH_MAX)
    else $error("value depth overflow");
  a_odep: assert property (@(posedge clk) disable iff (!rst_n) odep_r <= DEPTH_MAX)
    else $error("operator depth overflow");
  // a result is only produced from the end sequence
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_ENDFIN)
    else $error("result outside end");
`endif

endmodule

>>> verif/infix_rpn_expression_evaluator_top_test.sv
// testbench for infix_rpn_expression_evaluator_top: directed and random token streams in
// infix and postfix notation, checked against a built-in calculator predictor
// depends on irpn_pkg and the evaluator rtl
`timescale 1ns / 100ps
module infix_rpn_expression_evaluator_top_test;
  import irpn_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [7:0] MODE_INFIX   = 8'd0;
  localparam logic [7:0] MODE_POSTFIX = 8'd1;

  typedef struct packed {
    logic [3:0] digit;
    logic [3:0] func;
  } token_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [15:0] value;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;  // [3:0] func, [7:4] digit
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // [15:0] value, [17:16] error_code
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  infix_rpn_expression_evaluator_top dut (.*);

  // calculator predictor state
  logic [15:0] calc_vals [DEPTH];
  logic [2:0]  calc_ops [DEPTH];
  int          calc_vdepth, calc_odepth;
  logic [15:0] calc_acc;
  logic        calc_pending;
  logic [1:0]  calc_err;
  logic        calc_postfix;

  token_t  pending_tokens[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      answers_seen = 0;
  int      tokens_sent = 0;
  int      err_hist [4] = '{0, 0, 0, 0};
  bit      stimulus_done = 0;
  bit      hold_off = 0;
  bit      calm = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void flag_error(input logic [1:0] e);
    if (calc_err == ERR_NONE) calc_err = e;
  endfunction

  function automatic void push_val(input logic [15:0] v);
    if (calc_vdepth >= DEPTH) flag_error(ERR_OVER);
    else begin
      calc_vals[calc_vdepth] = v;
      calc_vdepth++;
    end
  endfunction

  function automatic void push_oper(input logic [2:0] op);
    if (calc_odepth >= DEPTH) flag_error(ERR_OVER);
    else begin
      calc_ops[calc_odepth] = op;
      calc_odepth++;
    end
  endfunction

  function automatic void close_number();
    if (calc_pending) begin
      push_val(calc_acc);
      calc_acc = '0;
      calc_pending = 1'b0;
    end
  endfunction

  function automatic void apply_oper(input logic [2:0] op);
    logic signed [15:0] a, b;
    logic signed [16:0] q;
    if (calc_vdepth < 2) begin
      flag_error(ERR_UNDER);
      return;
    end
    b = calc_vals[calc_vdepth-1];
    a = calc_vals[calc_vdepth-2];
    calc_vdepth -= 2;
    case (op)
      OP_PLUS:  push_val(a + b);
      OP_MINUS: push_val(a - b);
      OP_TIMES: push_val(a * b);
      default: begin
        if (b == 0) begin
          flag_error(ERR_DIV0);
          return;
        end
        q = 17'(a) / 17'(b);  // widened so most negative over -1 wraps to itself
        push_val(q[15:0]);
      end
    endcase
  endfunction

  function automatic int rank(input logic [2:0] op);
    return (op == OP_TIMES || op == OP_DIV) ? 2 : 1;
  endfunction

  function automatic void calc_clear();
    calc_vdepth = 0;
    calc_odepth = 0;
    calc_acc = '0;
    calc_pending = 1'b0;
    calc_err = ERR_NONE;
  endfunction

  // advance the calculator by one token, queueing an answer on end
  function automatic void calc_token(input token_t t);
    logic [2:0] top;
    answer_t ans;
    if (t.func == FN_END) begin
      if (calc_err == ERR_NONE) close_number();
      while (calc_err == ERR_NONE && calc_odepth > 0) begin
        calc_odepth--;
        top = calc_ops[calc_odepth];
        if (top == OP_OPEN) flag_error(ERR_UNDER);
        else apply_oper(top);
      end
      if (calc_err == ERR_NONE && calc_vdepth == 0) flag_error(ERR_UNDER);
      ans.value = (calc_err == ERR_NONE) ? calc_vals[calc_vdepth-1] : '0;
      ans.error_code = calc_err;
      expected_answers.push_back(ans);
      calc_clear();
      return;
    end
    if (calc_err != ERR_NONE || t.func > FN_END) return;
    if (t.func == FN_DIGIT) begin
      calc_acc = calc_acc * 16'd10 + 16'(t.digit);
      calc_pending = 1'b1;
      return;
    end
    close_number();
    if (calc_err != ERR_NONE || t.func == FN_SEP) return;
    if (calc_postfix) begin
      if (t.func <= FN_DIV) apply_oper(t.func[2:0]);
      return;
    end
    if (t.func <= FN_DIV) begin
      while (calc_err == ERR_NONE && calc_odepth > 0) begin
        top = calc_ops[calc_odepth-1];
        if (top == OP_OPEN || rank(top) < rank(t.func[2:0])) break;
        calc_odepth--;
        apply_oper(top);
      end
      if (calc_err == ERR_NONE) push_oper(t.func[2:0]);
    end else if (t.func == FN_OPEN) begin
      push_oper(OP_OPEN);
    end else begin
      while (calc_err == ERR_NONE && calc_odepth > 0 && calc_ops[calc_odepth-1] != OP_OPEN) begin
        calc_odepth--;
        apply_oper(calc_ops[calc_odepth]);
      end
      if (calc_err == ERR_NONE) begin
        if (calc_odepth == 0) flag_error(ERR_UNDER);
        else calc_odepth--;
      end
    end
  endfunction

  function automatic token_t tok(input logic [3:0] f, input logic [3:0] d = 4'd0);
    token_t t;
    t.func = f;
    t.digit = d;
    return t;
  endfunction

  // token transfers; prediction happens at acceptance
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      calc_token(token_t'(in_tdata));
      tokens_sent++;
    end
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_tokens.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        in_tdata <= pending_tokens.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // answer transfers and ready control
  always @(posedge clk) begin
    answer_t got, want;
    if (out_tvalid && out_tready) begin
      got = answer_t'(out_tdata[17:0]);
      answers_seen++;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected answer", int'(got.value), 0);
      end else begin
        want = expected_answers.pop_front();
        err_hist[want.error_code]++;
        if (got.value !== want.value)
          report_mismatch("value", int'(got.value), int'(want.value));
        if (got.error_code !== want.error_code)
          report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
      end
    end
    out_tready <= rst_n && !hold_off && (calm || $urandom_range(99) >= 13);
  end

  task automatic write_mode(input logic [7:0] mode);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_MODE;
    cfg_pwdata <= {24'd0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    calc_postfix = mode[0];
  endtask

  task automatic drain();
    while (pending_tokens.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    foreach (s[i]) pending_tokens.push_back(tok(FN_DIGIT, 4'(s[i] - "0")));
  endtask

  // well-formed infix expression with random content, bounded nesting
  task automatic add_infix(input int lvl);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) pending_tokens.push_back(tok(4'($urandom_range(FN_PLUS, FN_DIV))));
      if (lvl < 3 && $urandom_range(3) == 0) begin
        pending_tokens.push_back(tok(FN_OPEN));
        add_infix(lvl + 1);
        pending_tokens.push_back(tok(FN_CLOSE));
      end else begin
        add_number($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20));
      end
    end
  endtask

  task automatic add_postfix();
    int depth, ops;
    depth = 0;
    ops = $urandom_range(0, 6);
    while (ops > 0 || depth != 1) begin
      if (depth >= 2 && ops > 0 && $urandom_range(1)) begin
        pending_tokens.push_back(tok(4'($urandom_range(FN_PLUS, FN_DIV))));
        depth--;
        ops--;
      end else if (depth < 2 || ops > 0) begin
        add_number($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20));
        pending_tokens.push_back(tok(FN_SEP));
        depth++;
      end else begin
        pending_tokens.push_back(tok(FN_PLUS));
        depth--;
      end
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) pending_tokens.push_back(tok(4'($urandom_range(15)), 4'($urandom_range(15))));
  endtask

  task automatic random_phase(input int count);
    int start;
    start = pending_tokens.size();
    while (pending_tokens.size() - start < count) begin
      if ($urandom_range(9) < 8) begin
        if (calc_postfix) add_postfix();
        else add_infix(0);
        if ($urandom_range(7) == 0) add_noise($urandom_range(1, 4));
      end else begin
        add_noise($urandom_range(1, 10));
      end
      pending_tokens.push_back(tok(FN_END));
    end
  endtask

  initial begin
    calc_clear();
    calc_postfix = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed infix: precedence, parens, wrap, divide cases, errors
    add_number(65535); pending_tokens.push_back(tok(FN_TIMES)); add_number(2);
    pending_tokens.push_back(tok(FN_MINUS)); add_number(8);
    pending_tokens.push_back(tok(FN_DIV)); add_number(3);
    pending_tokens.push_back(tok(FN_END));
    pending_tokens.push_back(tok(FN_OPEN)); pending_tokens.push_back(tok(FN_DIGIT, 4'd15));
    pending_tokens.push_back(tok(FN_SEP)); pending_tokens.push_back(tok(FN_CLOSE));
    pending_tokens.push_back(tok(FN_END));
    add_number(7); pending_tokens.push_back(tok(FN_DIV)); add_number(0);
    pending_tokens.push_back(tok(FN_END));
    pending_tokens.push_back(tok(FN_CLOSE)); pending_tokens.push_back(tok(FN_END));
    pending_tokens.push_back(tok(FN_OPEN)); pending_tokens.push_back(tok(FN_END));
    pending_tokens.push_back(tok(FN_END));
    pending_tokens.push_back(tok(FN_PLUS)); pending_tokens.push_back(tok(FN_END));
    repeat (17) pending_tokens.push_back(tok(FN_OPEN));
    pending_tokens.push_back(tok(4'd12)); pending_tokens.push_back(tok(FN_END));
    drain();
    // directed postfix: most negative value, divide by -1, overflow, extra values, parens as separators
    write_mode(MODE_POSTFIX);
    add_number(0); pending_tokens.push_back(tok(FN_SEP)); add_number(32768);
    pending_tokens.push_back(tok(FN_MINUS)); add_number(1);
    pending_tokens.push_back(tok(FN_OPEN)); add_number(0); pending_tokens.push_back(tok(FN_SEP));
    add_number(1); pending_tokens.push_back(tok(FN_MINUS));
    pending_tokens.push_back(tok(FN_DIV)); pending_tokens.push_back(tok(FN_END));
    repeat (17) begin
      add_number(9); pending_tokens.push_back(tok(FN_CLOSE));
    end
    pending_tokens.push_back(tok(FN_END));
    add_number(3); pending_tokens.push_back(tok(FN_SEP)); add_number(4);
    pending_tokens.push_back(tok(FN_END));
    drain();
    // random phases in both notations, with a receiver hold-off
    random_phase(500);
    drain();
    write_mode(MODE_INFIX);
    random_phase(500);
    drain();
    write_mode(MODE_POSTFIX);
    calm = 1;
    random_phase(400);
    drain();
    calm = 0;
    write_mode(MODE_INFIX);
    random_phase(400);
    drain();
    stimulus_done = 1;
  end

  // receiver stall long enough to back up the input side
  initial begin
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (1500) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    wait (stimulus_done);
    $display("covered %0d tokens and %0d answers in infix and postfix notation",
             tokens_sent, answers_seen);
    $display("answers by error code ok/overflow/underflow/div0: %0d/%0d/%0d/%0d",
             err_hist[0], err_hist[1], err_hist[2], err_hist[3]);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("PASS infix_rpn_expression_evaluator_top");
    end else begin
      $display("FAIL infix_rpn_expression_evaluator_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL infix_rpn_expression_evaluator_top");
    $finish;
  end

endmodule
